FILE: hw/rtl/sprite_and_video_dma_controller_defines.svh
// Assertion macros used by the checker file of the DMA controller.
`ifndef SPRITE_AND_VIDEO_DMA_CONTROLLER_DEFINES_SVH
`define SPRITE_AND_VIDEO_DMA_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SADC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SADC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sadc_pkg.sv
// Shared types and constants of the sprite and video DMA controller.
package sadc_pkg;

    localparam logic [10:0] SPRITE_DMA_DELAY  = 11'd640;

    localparam logic [15:0] ADDR_SPRITE_DMA   = 16'hFF46;
    localparam logic [15:0] ADDR_HDMA1        = 16'hFF51;
    localparam logic [15:0] ADDR_HDMA2        = 16'hFF52;
    localparam logic [15:0] ADDR_HDMA3        = 16'hFF53;
    localparam logic [15:0] ADDR_HDMA4        = 16'hFF54;
    localparam logic [15:0] ADDR_HDMA5        = 16'hFF55;
    localparam logic [15:0] OAM_BASE          = 16'hFE00;
    localparam logic [15:0] OAM_TOP           = 16'hFE9F;
    localparam logic [11:0] SPRITE_COPY_BYTES = 12'd160;
    localparam logic [2:0]  VRAM_TOP_BITS     = 3'b100;
    localparam logic [4:0]  HDMA5_LOW_BITS    = 5'h1F;
    localparam logic [7:0]  OAM_BLOCKED_DATA  = 8'hFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_SPRITE = 2'd1,
        KIND_VIDEO  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        CMD_SPRITE_START,
        CMD_HDMA1,
        CMD_HDMA2,
        CMD_HDMA3,
        CMD_HDMA4,
        CMD_HDMA5,
        CMD_READ_STATUS,
        CMD_READ_OAM,
        CMD_READ_OTHER,
        CMD_TICK
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t   code;
        logic [7:0]  data;
        logic [5:0]  ticks;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic        claimed;
        logic [7:0]  rdata;
        logic [15:0] src;
        logic [15:0] dst;
        logic [11:0] count;
        logic        last;
    } result_t;

endpackage

FILE: hw/rtl/sadc_front.sv
// Front end: decodes each accepted word into a command for the queue, or drops it.
module sadc_front
    import sadc_pkg::*;
(
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    input  logic [5:0]  tick_cycles,
    input  logic        queue_full,
    output logic        push,
    output cmd_t        cmd
);

    logic useful;
    op_t  op;

    always_comb
    begin
        op          = op_t'(operation);
        useful      = 1'b1;
        cmd.code    = CMD_TICK;
        cmd.data    = write_data;
        cmd.ticks   = tick_cycles;
        unique case (op)
            OP_WRITE:
            begin
                priority if (bus_address == ADDR_SPRITE_DMA) cmd.code = CMD_SPRITE_START;
                else if (bus_address == ADDR_HDMA1)          cmd.code = CMD_HDMA1;
                else if (bus_address == ADDR_HDMA2)          cmd.code = CMD_HDMA2;
                else if (bus_address == ADDR_HDMA3)          cmd.code = CMD_HDMA3;
                else if (bus_address == ADDR_HDMA4)          cmd.code = CMD_HDMA4;
                else if (bus_address == ADDR_HDMA5)          cmd.code = CMD_HDMA5;
                else                                         useful   = 1'b0;
            end
            OP_READ:
            begin
                priority if (bus_address == ADDR_HDMA5)
                    cmd.code = CMD_READ_STATUS;
                else if (bus_address >= OAM_BASE && bus_address <= OAM_TOP)
                    cmd.code = CMD_READ_OAM;
                else
                    cmd.code = CMD_READ_OTHER;
            end
            OP_TICK:  cmd.code = CMD_TICK;
            OP_NONE:  useful   = 1'b0;
            default:  useful   = 1'b0;
        endcase
    end

    // writes to unknown addresses and the spare opcode are taken and dropped
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full && useful;

endmodule

FILE: hw/rtl/sadc_fifo.sv
// Short command queue between front and back end, flip-flop storage.
module sadc_fifo
    import sadc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/sadc_back.sv
// Back end: DMA state, command execution and the output/pending registers.
module sadc_back
    import sadc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic        sprite_busy_reg, sprite_busy_next;
    logic [10:0] elapsed_reg, elapsed_next;
    logic [7:0]  sprite_src_reg, sprite_src_next;
    logic        video_busy_reg, video_busy_next;
    logic [7:0]  vsrc_hi_reg, vsrc_hi_next;
    logic [3:0]  vsrc_lo_reg, vsrc_lo_next;
    logic [4:0]  vdst_hi_reg, vdst_hi_next;
    logic [3:0]  vdst_lo_reg, vdst_lo_next;
    logic [6:0]  vlen_reg, vlen_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        pend_valid_reg, pend_valid_next;
    result_t     pend_reg, pend_next;

    logic        can_load;
    logic [10:0] sum;
    logic        sprite_fire;
    logic [7:0]  len_plus;
    result_t     sprite_res, video_res, read_res;

    always_comb
    begin
        sum         = elapsed_reg + {5'b0, cmd.ticks};
        sprite_fire = sprite_busy_reg && (sum >= SPRITE_DMA_DELAY);
        len_plus    = {1'b0, vlen_reg} + 8'd1;

        sprite_res       = '0;
        sprite_res.kind  = KIND_SPRITE;
        sprite_res.src   = {sprite_src_reg, 8'h00};
        sprite_res.dst   = OAM_BASE;
        sprite_res.count = SPRITE_COPY_BYTES;
        sprite_res.last  = !video_busy_reg;

        video_res       = '0;
        video_res.kind  = KIND_VIDEO;
        video_res.src   = {vsrc_hi_reg, vsrc_lo_reg, 4'h0};
        video_res.dst   = {VRAM_TOP_BITS, vdst_hi_reg, vdst_lo_reg, 4'h0};
        video_res.count = {len_plus, 4'h0};
        video_res.last  = 1'b1;

        read_res      = '0;
        read_res.kind = KIND_READ;
        read_res.last = 1'b1;
        unique case (cmd.code)
            CMD_READ_STATUS:
            begin
                read_res.claimed = 1'b1;
                read_res.rdata   = {!video_busy_reg, 2'b00, HDMA5_LOW_BITS};
            end
            CMD_READ_OAM:
            begin
                if (sprite_busy_reg && elapsed_reg != '0)
                begin
                    read_res.claimed = 1'b1;
                    read_res.rdata   = OAM_BLOCKED_DATA;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sprite_busy_next = sprite_busy_reg;
        elapsed_next     = elapsed_reg;
        sprite_src_next  = sprite_src_reg;
        video_busy_next  = video_busy_reg;
        vsrc_hi_next     = vsrc_hi_reg;
        vsrc_lo_next     = vsrc_lo_reg;
        vdst_hi_next     = vdst_hi_reg;
        vdst_lo_next     = vdst_lo_reg;
        vlen_next        = vlen_reg;
        out_next         = out_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        pop              = 1'b0;

        can_load       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;

        if (pend_valid_reg)
        begin
            if (can_load)
            begin
                out_next        = pend_reg;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (cmd_valid && can_load)
        begin
            pop = 1'b1;
            unique case (cmd.code)
                CMD_SPRITE_START:
                begin
                    sprite_busy_next = 1'b1;
                    elapsed_next     = '0;
                    sprite_src_next  = cmd.data;
                end
                CMD_HDMA1: vsrc_hi_next = cmd.data;
                CMD_HDMA2: vsrc_lo_next = cmd.data[7:4];
                CMD_HDMA3: vdst_hi_next = cmd.data[4:0];
                CMD_HDMA4: vdst_lo_next = cmd.data[7:4];
                CMD_HDMA5:
                begin
                    vlen_next       = cmd.data[6:0];
                    video_busy_next = 1'b1;
                end
                CMD_READ_STATUS, CMD_READ_OAM, CMD_READ_OTHER:
                begin
                    out_next       = read_res;
                    out_valid_next = 1'b1;
                end
                CMD_TICK:
                begin
                    if (sprite_busy_reg)
                    begin
                        elapsed_next = sum;
                    end
                    if (sprite_fire)
                    begin
                        sprite_busy_next = 1'b0;
                        out_next         = sprite_res;
                        out_valid_next   = 1'b1;
                        if (video_busy_reg)
                        begin
                            pend_next       = video_res;
                            pend_valid_next = 1'b1;
                        end
                    end
                    else if (video_busy_reg)
                    begin
                        out_next       = video_res;
                        out_valid_next = 1'b1;
                    end
                    video_busy_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_busy_reg <= 1'b0;
            elapsed_reg     <= '0;
            sprite_src_reg  <= '0;
            video_busy_reg  <= 1'b0;
            vsrc_hi_reg     <= '0;
            vsrc_lo_reg     <= '0;
            vdst_hi_reg     <= '0;
            vdst_lo_reg     <= '0;
            vlen_reg        <= '0;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            sprite_busy_reg <= sprite_busy_next;
            elapsed_reg     <= elapsed_next;
            sprite_src_reg  <= sprite_src_next;
            video_busy_reg  <= video_busy_next;
            vsrc_hi_reg     <= vsrc_hi_next;
            vsrc_lo_reg     <= vsrc_lo_next;
            vdst_hi_reg     <= vdst_hi_next;
            vdst_lo_reg     <= vdst_lo_next;
            vlen_reg        <= vlen_next;
            out_valid_reg   <= out_valid_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

FILE: hw/rtl/sprite_and_video_dma_controller.sv
// Top level of the sprite (OAM) and video (HDMA) DMA controller.
//
//  channel   dir  tdata (low bit up)                         tuser         tlast
//  s_axis    in   bus_address, write_data, tick_cycles       operation     -
//  m_axis    out  read_claimed, read_data, source_address,   result_kind   last
//                 dest_address, byte_count
//
// One word is taken per cycle while the queue is not full. A word is decoded into the
// queue at the taking edge; the back end executes it from the queue head, and its result
// is registered in the output register once older commands are done and the output is free.
// A tick that fires both descriptors holds the back end while the video one is pending;
// the four-entry command queue absorbs that and any output stall, and input
// stalls only when the queue is full. Reset clears all DMA state and the queue.
module sprite_and_video_dma_controller
    import sadc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] bus_address, [23:16] write_data,
                                        // [29:24] tick_cycles, [31:30] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [0] read_claimed, [8:1] read_data,
                                        // [24:9] source_address, [40:25] dest_address,
                                        // [52:41] byte_count, [55:53] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast    // last
);

    logic    push, queue_full, pop, cmd_valid;
    cmd_t    front_cmd, head_cmd;
    result_t out_word;

    // decode
    sadc_front u_front (
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .operation   (s_axis_tuser),
        .bus_address (s_axis_tdata[15:0]),
        .write_data  (s_axis_tdata[23:16]),
        .tick_cycles (s_axis_tdata[29:24]),
        .queue_full  (queue_full),
        .push        (push),
        .cmd         (front_cmd)
    );

    // decoupling queue
    sadc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (cmd_valid),
        .head      (head_cmd)
    );

    // execution and output staging
    sadc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {3'b000, out_word.count, out_word.dst, out_word.src,
                           out_word.rdata, out_word.claimed};
    assign m_axis_tuser = out_word.kind;
    assign m_axis_tlast = out_word.last;

endmodule

FILE: hw/rtl/sadc_checker.sv
// Port-level checker for the DMA controller, bound to the top level.
`include "sprite_and_video_dma_controller_defines.svh"

module sadc_checker
    import sadc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic in_take;

    assign in_take = s_axis_tvalid && s_axis_tready && (s_axis_tdata[31:30] == 2'b00);

    // a stalled output word holds
    `SADC_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

    // a read reply shown in a cycle that takes an input word is the only word of its input
    `SADC_ASSERT_IMP(a_read_last, clk, rst_n, m_axis_tvalid && in_take && m_axis_tuser == KIND_READ, m_axis_tlast && m_axis_tdata[52:9] == '0, "read reply not last or carries copy fields")

    // a sprite descriptor always targets the sprite table with a full copy
    `SADC_ASSERT_IMP(a_sprite_desc, clk, rst_n, m_axis_tvalid && m_axis_tuser == KIND_SPRITE, m_axis_tdata[40:25] == OAM_BASE && m_axis_tdata[52:41] == SPRITE_COPY_BYTES && m_axis_tdata[16:9] == 8'h00 && m_axis_tdata[8:0] == '0, "bad sprite descriptor")

    // a video descriptor ends its tick and lands in video memory
    `SADC_ASSERT_IMP(a_video_desc, clk, rst_n, m_axis_tvalid && m_axis_tuser == KIND_VIDEO, m_axis_tlast && m_axis_tdata[40:38] == VRAM_TOP_BITS && m_axis_tdata[8:0] == '0, "bad video descriptor")

endmodule

bind sprite_and_video_dma_controller sadc_checker u_sadc_checker (.*);

FILE: tb/sprite_and_video_dma_controller_tb.sv
// Self-checking testbench for the sprite and video DMA controller.
`timescale 1ns / 1ps

module sprite_and_video_dma_controller_tb;
    import sadc_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [15:0] VRAM_BASE    = 16'h8000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predicted controller state
    logic        sprite_busy;
    logic [10:0] sprite_elapsed;
    logic [15:0] sprite_src;
    logic        video_busy;
    logic [15:0] video_src;
    logic [12:0] video_dst;
    logic [11:0] video_len;

    result_t     pending_replies[$];
    int          mismatches;
    int          cycle_count;
    bit          src_gaps;
    bit          sink_gaps;
    int          sink_hold_request;

    sprite_and_video_dma_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sprite_and_video_dma_controller verification failed");
            $finish;
        end
    end

    // Applies one accepted word to the predicted state and queues the replies it causes.
    function automatic void predict_controller(op_t op, logic [15:0] addr,
                                               logic [7:0] wdata, logic [5:0] ticks);
        result_t outs[2];
        int      n;
        n = 0;
        outs[0] = '0;
        outs[1] = '0;
        case (op)
            OP_WRITE:
            begin
                case (addr)
                    ADDR_SPRITE_DMA:
                    begin
                        sprite_busy    = 1'b1;
                        sprite_elapsed = '0;
                        sprite_src     = {wdata, 8'h00};
                    end
                    ADDR_HDMA1: video_src = {wdata, video_src[7:0]};
                    ADDR_HDMA2: video_src = {video_src[15:8], wdata[7:4], 4'h0};
                    ADDR_HDMA3: video_dst = {wdata[4:0], video_dst[7:0]};
                    ADDR_HDMA4: video_dst = {video_dst[12:8], wdata[7:4], 4'h0};
                    ADDR_HDMA5:
                    begin
                        // mode bit only paces hblank copies, which live outside the block
                        video_len  = ({5'd0, wdata[6:0]} + 12'd1) << 4;
                        video_busy = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_READ:
            begin
                outs[0].kind = KIND_READ;
                if (addr == ADDR_HDMA5)
                begin
                    outs[0].claimed = 1'b1;
                    outs[0].rdata   = {~video_busy, 2'b00, HDMA5_LOW_BITS};
                end
                else if (sprite_busy && sprite_elapsed != 0 &&
                         addr >= OAM_BASE && addr <= OAM_TOP)
                begin
                    outs[0].claimed = 1'b1;
                    outs[0].rdata   = OAM_BLOCKED_DATA;
                end
                n = 1;
            end
            OP_TICK:
            begin
                if (sprite_busy)
                begin
                    sprite_elapsed = sprite_elapsed + {5'd0, ticks};
                    if (sprite_elapsed >= SPRITE_DMA_DELAY)
                    begin
                        outs[n].kind  = KIND_SPRITE;
                        outs[n].src   = sprite_src;
                        outs[n].dst   = OAM_BASE;
                        outs[n].count = SPRITE_COPY_BYTES;
                        sprite_busy   = 1'b0;
                        n++;
                    end
                end
                if (video_busy)
                begin
                    outs[n].kind  = KIND_VIDEO;
                    outs[n].src   = video_src;
                    outs[n].dst   = VRAM_BASE + {3'b000, video_dst};
                    outs[n].count = video_len;
                    video_busy    = 1'b0;
                    n++;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            outs[i].last = (i == n - 1);
            pending_replies.push_back(outs[i]);
        end
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every output word against the oldest prediction.
    always @(posedge clk)
    begin : reply_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("output word with no prediction pending: tuser=%0d tdata=0x%0h",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("result_kind",    want.kind,    m_axis_tuser);
                check_field("read_claimed",   want.claimed, m_axis_tdata[0]);
                check_field("read_data",      want.rdata,   m_axis_tdata[8:1]);
                check_field("source_address", want.src,     m_axis_tdata[24:9]);
                check_field("dest_address",   want.dst,     m_axis_tdata[40:25]);
                check_field("byte_count",     want.count,   m_axis_tdata[52:41]);
                check_field("last",           want.last,    m_axis_tlast);
            end
        end
    end

    // Output side: short random stalls, plus a long hold when a test asks for one.
    initial
    begin : sink_side
        int hold_len;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (sink_hold_request > 0)
            begin
                hold_len = sink_hold_request;
                sink_hold_request = 0;
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offer one word and wait for the handshake. Valid stays high on return so that the
    // next word can follow back to back; drain_replies drops it.
    task automatic send_word(op_t op, logic [15:0] addr, logic [7:0] wdata, logic [5:0] ticks);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, ticks, wdata, addr};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_controller(op, addr, wdata, ticks);
    endtask

    // Sender pause: stop offering until every predicted word has come out.
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 6))
            0:       return ADDR_SPRITE_DMA;
            1:       return ADDR_HDMA1 + 16'($urandom_range(0, 4));
            2, 3:    return OAM_BASE + 16'($urandom_range(0, 159));
            4:       return $urandom_range(0, 1) ? OAM_BASE - 16'd1 : OAM_TOP + 16'd1;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic test_directed_cases();
        send_word(OP_READ, ADDR_HDMA5, 8'h00, 6'd0);        // status while idle
        send_word(OP_READ, OAM_BASE, 8'h00, 6'd0);          // OAM readable when no DMA
        send_word(OP_READ, 16'h0000, 8'hFF, 6'h3F);
        send_word(OP_READ, 16'hFFFF, 8'h00, 6'd0);
        send_word(OP_TICK, 16'hFFFF, 8'hFF, 6'd0);          // tick with nothing armed
        send_word(OP_NONE, ADDR_SPRITE_DMA, 8'hFF, 6'h3F);  // unknown op ignored
        send_word(OP_WRITE, 16'h1234, 8'hAA, 6'd0);         // not a register
        send_word(OP_WRITE, ADDR_SPRITE_DMA, 8'hFF, 6'd0);
        send_word(OP_READ, OAM_BASE, 8'h00, 6'd0);          // armed but nothing elapsed yet
        send_word(OP_TICK, 16'h0000, 8'h00, 6'h3F);
        send_word(OP_READ, OAM_BASE, 8'h00, 6'd0);
        send_word(OP_READ, OAM_TOP, 8'h00, 6'd0);
        send_word(OP_READ, OAM_TOP + 16'd1, 8'h00, 6'd0);
        send_word(OP_READ, OAM_BASE - 16'd1, 8'h00, 6'd0);
        send_word(OP_READ, ADDR_SPRITE_DMA, 8'h00, 6'd0);
        // video channel with every address bit set; restarted sprite DMA with source 0
        send_word(OP_WRITE, ADDR_HDMA1, 8'hFF, 6'd0);
        send_word(OP_WRITE, ADDR_HDMA2, 8'hFF, 6'd0);
        send_word(OP_WRITE, ADDR_HDMA3, 8'hFF, 6'd0);
        send_word(OP_WRITE, ADDR_HDMA4, 8'hFF, 6'd0);
        send_word(OP_WRITE, ADDR_HDMA5, 8'hFF, 6'd0);       // longest, hblank mode
        send_word(OP_READ, ADDR_HDMA5, 8'h00, 6'd0);        // busy status
        send_word(OP_WRITE, ADDR_SPRITE_DMA, 8'h00, 6'd0);  // retrigger while busy
        for (int i = 0; i < 10; i++)
            send_word(OP_TICK, 16'h0000, 8'h00, 6'h3F);     // sprite stays short of its delay; the first gives video
        send_word(OP_WRITE, ADDR_HDMA1, 8'h00, 6'd0);
        send_word(OP_WRITE, ADDR_HDMA2, 8'h00, 6'd0);
        send_word(OP_WRITE, ADDR_HDMA3, 8'h00, 6'd0);
        send_word(OP_WRITE, ADDR_HDMA4, 8'h00, 6'd0);
        send_word(OP_WRITE, ADDR_HDMA5, 8'h00, 6'd0);       // shortest, general mode
        send_word(OP_TICK, 16'h0000, 8'h00, 6'd10);         // reaches delay: both descriptors
        send_word(OP_READ, ADDR_HDMA5, 8'h00, 6'd0);
        drain_replies();
    endtask

    task automatic test_random_traffic(int word_goal);
        int sent;
        sent = 0;
        while (sent < word_goal)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:
                    send_word(OP_TICK, 16'($urandom()), 8'($urandom()),
                              6'($urandom_range(0, 63)));
                7, 8, 9, 10:
                    send_word(OP_READ, pick_address(), 8'($urandom()), 6'($urandom()));
                11, 12:
                begin
                    // full video programming sequence, then the tick that fires it
                    send_word(OP_WRITE, ADDR_HDMA1, 8'($urandom()), 6'($urandom()));
                    send_word(OP_WRITE, ADDR_HDMA2, 8'($urandom()), 6'($urandom()));
                    send_word(OP_WRITE, ADDR_HDMA3, 8'($urandom()), 6'($urandom()));
                    send_word(OP_WRITE, ADDR_HDMA4, 8'($urandom()), 6'($urandom()));
                    send_word(OP_WRITE, ADDR_HDMA5, 8'($urandom()), 6'($urandom()));
                    if ($urandom_range(0, 3) != 0)
                        send_word(OP_READ, ADDR_HDMA5, 8'($urandom()), 6'($urandom()));
                    send_word(OP_TICK, 16'($urandom()), 8'($urandom()), 6'($urandom()));
                    sent += 5;
                end
                13:
                    send_word(OP_WRITE, ADDR_SPRITE_DMA, 8'($urandom()), 6'($urandom()));
                14, 15:
                    send_word(OP_WRITE, pick_address(), 8'($urandom()), 6'($urandom()));
                16:
                begin
                    send_word(OP_NONE, 16'($urandom()), 8'($urandom()), 6'($urandom()));
                    sent--;   // ignored by the block
                end
                default:
                    send_word(OP_READ,
                              $urandom_range(0, 1) ? ADDR_HDMA5
                                                   : OAM_BASE + 16'($urandom_range(0, 159)),
                              8'($urandom()), 6'($urandom()));
            endcase
            sent++;
        end
        drain_replies();
    endtask

    task automatic test_backpressure();
        // receiver holds off while reads keep coming: queue fills, input stalls
        sink_hold_request = 150;
        for (int i = 0; i < 20; i++)
            send_word(OP_READ, $urandom_range(0, 1) ? ADDR_HDMA5 : pick_address(),
                      8'($urandom()), 6'($urandom()));
        send_word(OP_WRITE, ADDR_SPRITE_DMA, 8'($urandom()), 6'd0);
        send_word(OP_WRITE, ADDR_HDMA5, 8'($urandom()), 6'd0);
        for (int i = 0; i < 11; i++)
            send_word(OP_TICK, 16'h0000, 8'h00, 6'h3F);
        drain_replies();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        s_axis_tvalid     <= 1'b0;
        s_axis_tdata      <= '0;
        s_axis_tuser      <= OP_NONE;
        mismatches        = 0;
        cycle_count       = 0;
        sink_hold_request = 0;
        src_gaps          = 1'b0;
        sink_gaps         = 1'b0;
        sprite_busy       = 1'b0;
        sprite_elapsed    = '0;
        sprite_src        = '0;
        video_busy        = 1'b0;
        video_src         = '0;
        video_dst         = '0;
        video_len         = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        test_random_traffic(480);
        test_backpressure();
        // closing stretch at full rate on both sides
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        test_random_traffic(100);

        if (mismatches == 0)
            $display("sprite_and_video_dma_controller verification clean");
        else
            $display("sprite_and_video_dma_controller verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/sadc_pkg.sv
hw/rtl/sadc_front.sv
hw/rtl/sadc_fifo.sv
hw/rtl/sadc_back.sv
hw/rtl/sprite_and_video_dma_controller.sv
hw/rtl/sadc_checker.sv
tb/sprite_and_video_dma_controller_tb.sv
